>>> design/sc1a_pkg.sv
// Package for the scan-code set 1 to ASCII decoder.
// Holds the request run type, scan-code constants and the UK key tables.
// No dependencies.
package sc1a_pkg;

    localparam int unsigned RUN_MAX   = 4;
    localparam int unsigned RUN_CNT_W = $clog2(RUN_MAX + 1);
    localparam int unsigned RUN_IDX_W = $clog2(RUN_MAX);
    localparam int unsigned TABLE_LEN = 84;

    // Scan codes with a meaning of their own
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_BACKSPACE    = 8'h0E;
    localparam logic [7:0] SC_EXT_PREFIX   = 8'hE0;
    localparam logic [7:0] SC_ARROW_UP     = 8'h48;
    localparam logic [7:0] SC_ARROW_LEFT   = 8'h4B;
    localparam logic [7:0] SC_ARROW_DOWN   = 8'h50;
    localparam logic [7:0] SC_ARROW_RIGHT  = 8'h4D;

    // Characters emitted by the special keys
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_ONE   = 8'h31;

    // Bytes produced by one input byte
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    cnt;
    } t_run;

    // Plain column, UK layout; zero means no character
    function automatic logic [7:0] key_plain(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h02: ch = "1";
            7'h03: ch = "2";
            7'h04: ch = "3";
            7'h05: ch = "4";
            7'h06: ch = "5";
            7'h07: ch = "6";
            7'h08: ch = "7";
            7'h09: ch = "8";
            7'h0A: ch = "9";
            7'h0B: ch = "0";
            7'h0C: ch = "-";
            7'h0D: ch = "=";
            7'h0F: ch = 8'h09;
            7'h10: ch = "q";
            7'h11: ch = "w";
            7'h12: ch = "e";
            7'h13: ch = "r";
            7'h14: ch = "t";
            7'h15: ch = "y";
            7'h16: ch = "u";
            7'h17: ch = "i";
            7'h18: ch = "o";
            7'h19: ch = "p";
            7'h1A: ch = "[";
            7'h1B: ch = "]";
            7'h1C: ch = 8'h0A;
            7'h1E: ch = "a";
            7'h1F: ch = "s";
            7'h20: ch = "d";
            7'h21: ch = "f";
            7'h22: ch = "g";
            7'h23: ch = "h";
            7'h24: ch = "j";
            7'h25: ch = "k";
            7'h26: ch = "l";
            7'h27: ch = ";";
            7'h28: ch = 8'h27;
            7'h29: ch = "#";
            7'h2B: ch = 8'h5C;
            7'h2C: ch = "z";
            7'h2D: ch = "x";
            7'h2E: ch = "c";
            7'h2F: ch = "v";
            7'h30: ch = "b";
            7'h31: ch = "n";
            7'h32: ch = "m";
            7'h33: ch = ",";
            7'h34: ch = ".";
            7'h35: ch = "/";
            7'h37: ch = "*";
            7'h39: ch = " ";
            7'h4A: ch = "-";
            7'h4E: ch = "+";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Shifted column, UK layout; zero means no character
    function automatic logic [7:0] key_shifted(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h02: ch = "!";
            7'h03: ch = 8'h22;
            7'h04: ch = "#";
            7'h05: ch = "$";
            7'h06: ch = "%";
            7'h07: ch = "^";
            7'h08: ch = "&";
            7'h09: ch = "*";
            7'h0A: ch = "(";
            7'h0B: ch = ")";
            7'h0C: ch = "_";
            7'h0D: ch = "+";
            7'h0F: ch = 8'h09;
            7'h10: ch = "Q";
            7'h11: ch = "W";
            7'h12: ch = "E";
            7'h13: ch = "R";
            7'h14: ch = "T";
            7'h15: ch = "Y";
            7'h16: ch = "U";
            7'h17: ch = "I";
            7'h18: ch = "O";
            7'h19: ch = "P";
            7'h1A: ch = "{";
            7'h1B: ch = "}";
            7'h1C: ch = 8'h0A;
            7'h1E: ch = "A";
            7'h1F: ch = "S";
            7'h20: ch = "D";
            7'h21: ch = "F";
            7'h22: ch = "G";
            7'h23: ch = "H";
            7'h24: ch = "J";
            7'h25: ch = "K";
            7'h26: ch = "L";
            7'h27: ch = ":";
            7'h28: ch = "@";
            7'h29: ch = "~";
            7'h2B: ch = "|";
            7'h2C: ch = "Z";
            7'h2D: ch = "X";
            7'h2E: ch = "C";
            7'h2F: ch = "V";
            7'h30: ch = "B";
            7'h31: ch = "N";
            7'h32: ch = "M";
            7'h33: ch = "<";
            7'h34: ch = ">";
            7'h35: ch = "?";
            7'h37: ch = "*";
            7'h39: ch = " ";
            7'h4A: ch = "-";
            7'h4E: ch = "+";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> design/scancode_set1_to_ascii.sv
// An accepted scan byte passes the input register and run buffer into the output register.
// Throughput: one output byte per cycle while the receiver does not stall; a scan byte
// yields N (0..4) bytes; the next is taken when the run buffer is empty or sends its last.
// Reset (synchronous, active low) clears shift and prefix flags and empties all stages.
// Depends on sc1a_pkg and sc1a_decode.
module scancode_set1_to_ascii
    import sc1a_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_scan_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run
);

    logic                         r_in_vld;
    logic [7:0]                   r_in_byte;
    logic [RUN_MAX-1:0][7:0]      r_run_bytes;
    logic [RUN_CNT_W-1:0]         r_run_cnt;
    logic [RUN_IDX_W-1:0]         r_run_idx;
    logic                         r_o_vld;
    logic [7:0]                   r_o_char;
    logic                         r_o_last;
    logic                         out_free;
    logic                         out_load;
    logic                         in_take;
    t_run                         dec_run;

    // Handshake control
    always_comb begin
        out_free = !r_o_vld || !i_stall;
        out_load = out_free && (r_run_cnt != '0);
        in_take  = r_in_vld &&
                   ((r_run_cnt == '0) || ((r_run_cnt == RUN_CNT_W'(1)) && out_free));
        o_stall  = r_in_vld && !in_take;
    end

    sc1a_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (r_in_byte),
        .i_take  (in_take),
        .o_run   (dec_run)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_scan_byte;
        end
    end

    // Run buffer: holds the bytes of one request, drained one a cycle while the output is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_cnt <= '0;
            r_run_idx <= '0;
        end else if (in_take) begin
            r_run_cnt <= dec_run.cnt;
            r_run_idx <= '0;
        end else if (out_load) begin
            r_run_cnt <= r_run_cnt - RUN_CNT_W'(1);
            r_run_idx <= r_run_idx + RUN_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_run_bytes <= dec_run.bytes;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_load) begin
            r_o_vld <= 1'b1;
        end else if (!i_stall) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_char <= r_run_bytes[r_run_idx];
            r_o_last <= (r_run_cnt == RUN_CNT_W'(1));
        end
    end

    assign o_valid       = r_o_vld;
    assign o_out_char    = r_o_char;
    assign o_last_of_run = r_o_last;

endmodule

>>> design/sc1a_decode.sv
// Scan-byte decoder: shift and E0-prefix flags plus the byte-to-run lookup.
// Depends on sc1a_pkg.
module sc1a_decode
    import sc1a_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_code,
    input  logic       i_take,
    output t_run       o_run
);

    logic r_shift_held;
    logic r_prefix_pending;
    logic n_shift_held;
    logic n_prefix_pending;
    logic [7:0] key_ch;

    // Table lookup for ordinary make codes
    always_comb begin
        key_ch = r_shift_held ? key_shifted(i_code[6:0]) : key_plain(i_code[6:0]);
        if (i_code[7] || (i_code >= 8'(TABLE_LEN))) begin
            key_ch = 8'h00;
        end
    end

    // Run and flag update for the byte in the input register
    always_comb begin
        o_run            = '0;
        n_shift_held     = r_shift_held;
        n_prefix_pending = 1'b0;
        if (r_prefix_pending) begin
            // second byte of an extended code: only arrows produce output
            o_run.bytes[0] = CH_ESC;
            o_run.bytes[1] = CH_LBRK;
            o_run.bytes[2] = CH_ONE;
            case (i_code)
                SC_ARROW_UP: begin
                    o_run.bytes[3] = "A";
                    o_run.cnt      = RUN_CNT_W'(4);
                end
                SC_ARROW_DOWN: begin
                    o_run.bytes[3] = "B";
                    o_run.cnt      = RUN_CNT_W'(4);
                end
                SC_ARROW_RIGHT: begin
                    o_run.bytes[3] = "C";
                    o_run.cnt      = RUN_CNT_W'(4);
                end
                SC_ARROW_LEFT: begin
                    o_run.bytes[3] = "D";
                    o_run.cnt      = RUN_CNT_W'(4);
                end
                default: begin
                    o_run.cnt = '0;
                end
            endcase
        end else begin
            case (i_code)
                SC_LSHIFT_MAKE: begin
                    n_shift_held = 1'b1;
                end
                SC_LSHIFT_BREAK: begin
                    n_shift_held = 1'b0;
                end
                SC_EXT_PREFIX: begin
                    n_prefix_pending = 1'b1;
                end
                SC_BACKSPACE: begin
                    o_run.bytes[0] = CH_BS;
                    o_run.bytes[1] = CH_SPACE;
                    o_run.bytes[2] = CH_BS;
                    o_run.cnt      = RUN_CNT_W'(3);
                end
                default: begin
                    o_run.bytes[0] = key_ch;
                    o_run.cnt      = (key_ch != 8'h00) ? RUN_CNT_W'(1) : '0;
                end
            endcase
        end
    end

    // Flags advance only when the request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_held     <= 1'b0;
            r_prefix_pending <= 1'b0;
        end else if (i_take) begin
            r_shift_held     <= n_shift_held;
            r_prefix_pending <= n_prefix_pending;
        end
    end

endmodule

>>> bench/scan_char_checker.sv
// Checker for the scan-code set 1 to ASCII decoder: watches both request channels,
// predicts the characters of every accepted scan byte and compares them in order.
// Depends on sc1a_pkg for scan-code and character constants.
module scan_char_checker
    import sc1a_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_scan_valid,
    input  logic       i_scan_stall,
    input  logic [7:0] i_scan_byte,
    input  logic       i_char_valid,
    input  logic       i_char_stall,
    input  logic [7:0] i_out_char,
    input  logic       i_last_of_run,
    output int         o_mismatches,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_exp;

    t_char_exp  expected_chars[$];
    logic [7:0] plain_keys   [TABLE_LEN];
    logic [7:0] shifted_keys [TABLE_LEN];
    logic       shift_on;
    logic       ext_pending;
    int         mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // UK layout, one row of the keyboard per line; zero means no character
    initial begin
        plain_keys = '{
            8'h00, 8'h00, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h00,
            8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0A, 8'h00,
            "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, "#",
            8'h00, 8'h5C, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'h00,
            "*", 8'h00, " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, "-", 8'h00, 8'h00, 8'h00, "+", 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00
        };
        shifted_keys = '{
            8'h00, 8'h00, "!", 8'h22, "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'h00,
            8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'h0A, 8'h00,
            "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", "@", "~",
            8'h00, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'h00,
            "*", 8'h00, " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, "-", 8'h00, 8'h00, 8'h00, "+", 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00
        };
    end

    task automatic report_mismatch(input string what, input logic [7:0] got_ch,
                                   input logic got_last, input t_char_exp want);
        $display("%0t ns: %s: got char %02h last %0b, want char %02h last %0b",
                 $realtime, what, got_ch, got_last, want.ch, want.last);
        mismatch_count++;
    endtask

    // Decode one scan byte and queue the characters it should produce
    task automatic decode_scan_byte(input logic [7:0] code);
        logic [7:0] run [4];
        logic [7:0] dir;
        int         n;
        n = 0;
        dir = 8'h00;
        if (ext_pending) begin
            // second byte of an extended code: only arrow makes give output
            ext_pending = 1'b0;
            case (code)
                SC_ARROW_UP:    dir = "A";
                SC_ARROW_DOWN:  dir = "B";
                SC_ARROW_RIGHT: dir = "C";
                SC_ARROW_LEFT:  dir = "D";
                default:        dir = 8'h00;
            endcase
            if (dir != 8'h00) begin
                run = '{CH_ESC, CH_LBRK, CH_ONE, dir};
                n = 4;
            end
        end else begin
            case (code)
                SC_LSHIFT_MAKE:  shift_on = 1'b1;
                SC_LSHIFT_BREAK: shift_on = 1'b0;
                SC_EXT_PREFIX:   ext_pending = 1'b1;
                SC_BACKSPACE: begin
                    run = '{CH_BS, CH_SPACE, CH_BS, 8'h00};
                    n = 3;
                end
                default: begin
                    // break codes and codes past the table are silent
                    if (!code[7] && code < TABLE_LEN) begin
                        run[0] = shift_on ? shifted_keys[code[6:0]] : plain_keys[code[6:0]];
                        if (run[0] != 8'h00)
                            n = 1;
                    end
                end
            endcase
        end
        for (int k = 0; k < n; k++)
            expected_chars.push_back('{ch: run[k], last: (k == n - 1)});
    endtask

    // Predict on accepted scan bytes, compare on accepted characters
    always @(posedge i_clk) begin
        t_char_exp want;
        if (!i_rst_n) begin
            shift_on = 1'b0;
            ext_pending = 1'b0;
            expected_chars.delete();
        end else begin
            if (i_scan_valid && !i_scan_stall)
                decode_scan_byte(i_scan_byte);
            if (i_char_valid && !i_char_stall) begin
                if (expected_chars.size() == 0) begin
                    want = '{ch: 8'h00, last: 1'b0};
                    report_mismatch("unexpected character", i_out_char, i_last_of_run, want);
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_char !== want.ch)
                        report_mismatch("wrong character", i_out_char, i_last_of_run, want);
                    if (i_last_of_run !== want.last)
                        report_mismatch("wrong end of run", i_out_char, i_last_of_run, want);
                end
            end
        end
        o_pending <= expected_chars.size();
    end

endmodule

>>> bench/scancode_set1_to_ascii_test.sv
// Testbench top for the scan-code set 1 to ASCII decoder: clock, reset, scan byte
// stimulus and receiver stalls. Checking is done by scan_char_checker.
// Depends on sc1a_pkg, scancode_set1_to_ascii and scan_char_checker.
module scancode_set1_to_ascii_test
    import sc1a_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       scan_valid = 1'b0;
    logic       scan_stall;
    logic [7:0] scan_byte = 8'h00;
    logic       char_valid;
    logic       char_stall = 1'b0;
    logic [7:0] out_char;
    logic       last_of_run;
    logic       calm = 1'b0;
    logic       hold_on = 1'b0;
    int         sent_count = 0;
    int         cycle_count = 0;
    int         mismatches;
    int         pending;

    always #2 clk = ~clk;

    scancode_set1_to_ascii dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (scan_valid),
        .o_stall       (scan_stall),
        .i_scan_byte   (scan_byte),
        .o_valid       (char_valid),
        .i_stall       (char_stall),
        .o_out_char    (out_char),
        .o_last_of_run (last_of_run)
    );

    scan_char_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_scan_valid  (scan_valid),
        .i_scan_stall  (scan_stall),
        .i_scan_byte   (scan_byte),
        .i_char_valid  (char_valid),
        .i_char_stall  (char_stall),
        .i_out_char    (out_char),
        .i_last_of_run (last_of_run),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** scancode_set1_to_ascii: FAILED **");
            $finish;
        end
    end

    // Offer one scan byte after a random gap and hold it until accepted
    task automatic send_scan(input logic [7:0] code);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            scan_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan_valid <= 1'b1;
        scan_byte <= code;
        do @(posedge clk); while (scan_stall);
        sent_count++;
    endtask

    // Receiver: random stall before each character, plus the long hold-off
    initial begin
        int gap;
        wait (rst_n);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 5);
            while (gap > 0 || hold_on) begin
                char_stall <= 1'b1;
                @(posedge clk);
                if (gap > 0)
                    gap--;
            end
            char_stall <= 1'b0;
            do @(posedge clk); while (!char_valid);
        end
    end

    // Long hold-off on the output so the decoder backs up and stalls its input
    initial begin
        wait (sent_count >= 120);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Stimulus and verdict
    initial begin
        logic [7:0] code;
        int         kind;
        int         random_start;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, table edges, shift, backspace, every arrow, odd prefixes
        send_scan(8'h00);
        send_scan(8'h02);
        send_scan(8'h0F);
        send_scan(8'h1C);
        send_scan(SC_BACKSPACE);
        send_scan(SC_LSHIFT_MAKE);
        send_scan(8'h02);
        send_scan(8'h0F);
        send_scan(8'h53);
        send_scan(8'h54);
        send_scan(8'h7F);
        send_scan(SC_LSHIFT_BREAK);
        send_scan(8'h9E);
        send_scan(8'hFF);
        send_scan(SC_EXT_PREFIX);
        send_scan(SC_ARROW_UP);
        send_scan(SC_EXT_PREFIX);
        send_scan(SC_ARROW_DOWN);
        send_scan(SC_EXT_PREFIX);
        send_scan(SC_ARROW_RIGHT);
        send_scan(SC_EXT_PREFIX);
        send_scan(SC_ARROW_LEFT);
        send_scan(SC_EXT_PREFIX);
        send_scan(SC_EXT_PREFIX);
        send_scan(SC_EXT_PREFIX);
        send_scan(SC_LSHIFT_MAKE);
        send_scan(8'h10);

        // random: mostly key presses, shift and arrow sequences, some noise
        random_start = sent_count;
        while (sent_count - random_start < RANDOM_ITEMS) begin
            if ((sent_count / 40) % 2 == 1)
                calm <= 1'b1;
            else
                calm <= 1'b0;
            kind = $urandom_range(0, 99);
            code = 8'($urandom_range(0, TABLE_LEN - 1));
            if (kind < 40) begin
                send_scan(code);
            end else if (kind < 50) begin
                send_scan($urandom_range(0, 1) ? SC_LSHIFT_MAKE : SC_LSHIFT_BREAK);
            end else if (kind < 62) begin
                send_scan(SC_EXT_PREFIX);
                case ($urandom_range(0, 3))
                    0: send_scan(SC_ARROW_UP);
                    1: send_scan(SC_ARROW_DOWN);
                    2: send_scan(SC_ARROW_RIGHT);
                    default: send_scan(SC_ARROW_LEFT);
                endcase
            end else if (kind < 67) begin
                send_scan(SC_EXT_PREFIX);
                send_scan(8'($urandom_range(0, 255)));
            end else if (kind < 72) begin
                send_scan(SC_BACKSPACE);
            end else if (kind < 87) begin
                // press and release of one key
                send_scan(code);
                send_scan(code | 8'h80);
            end else begin
                send_scan(8'($urandom_range(0, 255)));
            end
        end
        scan_valid <= 1'b0;

        // drain, then allow for stray characters
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0) begin
            $display("** scancode_set1_to_ascii: PASSED **");
        end else begin
            if (pending != 0)
                $display("%0d characters never arrived", pending);
            $display("** scancode_set1_to_ascii: FAILED **");
        end
        $finish;
    end

endmodule
